// ===== sv/chm_pkg.sv =====
// Package for the compass heading block: datapath widths, constants and the
// arctangent table of the vectoring CORDIC. No dependencies.
package chm_pkg;

  // Axis values carry 32 fraction bits; 16 integer bits, CORDIC growth and sign fit in 52.
  localparam int unsigned XY_W       = 52;
  // Angle in degrees with 24 fraction bits; magnitude stays below 2^32.
  localparam int unsigned Z_W        = 34;
  localparam int unsigned ANGLE_FRAC = 24;
  localparam int unsigned XY_FRAC    = 32;
  localparam int unsigned HEAD_W     = 9;
  localparam int unsigned TABLE_LEN  = 32;

  localparam logic [HEAD_W-1:0] HALF_TURN_DEG = 9'd180;
  localparam logic [HEAD_W-1:0] FULL_TURN_DEG = 9'd360;
  localparam logic signed [Z_W-1:0] QUARTER_TURN_Z = 34'sd1509949440;  // 90 << 24

  // atan(2^-i) in degrees, 24 fraction bits, rounded.
  localparam logic signed [Z_W-1:0] ATAN_TAB [TABLE_LEN] = '{
    34'sd754974720, 34'sd445687602, 34'sd235489088, 34'sd119537938,
    34'sd60000934,  34'sd30029717,  34'sd15018523,  34'sd7509720,
    34'sd3754917,   34'sd1877466,   34'sd938734,    34'sd469367,
    34'sd234684,    34'sd117342,    34'sd58671,     34'sd29335,
    34'sd14668,     34'sd7334,      34'sd3667,      34'sd1833,
    34'sd917,       34'sd458,       34'sd229,       34'sd115,
    34'sd57,        34'sd29,        34'sd14,        34'sd7,
    34'sd4,         34'sd2,         34'sd1,         34'sd0
  };

  // Special cases decided at the input and carried down the pipeline.
  typedef struct packed {
    logic yzero;  // Y sample is zero: heading is exact, the CORDIC result is ignored
    logic xneg;   // X sample is negative
  } chm_flags_t;

endpackage

// ===== sv/compass_heading_from_magnetometer.sv =====
// Compass heading from one magnetometer sample: byte joining, quadrant fold,
// an unrolled vectoring CORDIC and the final floor and clamp. Uses chm_pkg.
//
// Usage: each input word carries the little-endian X and Y byte pairs of one
// magnetometer sample. The block joins them into signed 16-bit values and
// returns floor(atan2(y, x) in degrees + 180), from 0 to 360, one output word
// per input word, in order.
// A zero Y sample bypasses the arithmetic: 180 for X >= 0, 360 for X < 0.
// Each accepted word passes through the join and fold stage, one stage per
// CORDIC iteration and the output register. Throughput is one word per cycle
// while no word waits at a stalled output; each pipeline stage holds one word
// and its valid bit travels with it.
// When the receiver stalls with a word waiting at the output, the whole
// pipeline holds its contents and s_axis_tready_o falls, so no word is dropped
// or repeated; a bubble-free stream resumes when m_axis_tready_i returns high.
// Reset clears every valid bit, so the output channel is empty after reset.
// Each CORDIC stage carries one 52-bit add and subtract pair on X and Y plus
// one 34-bit angle add, which sets the cycle time.
module compass_heading_from_magnetometer
  import chm_pkg::*;
#(
  parameter int unsigned CORDIC_STEPS = 24  // 16 to 32 iterations
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [7:0] x_low_byte, [15:8] x_high_byte, [23:16] y_low_byte, [31:24] y_high_byte
  input  logic [31:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [8:0] heading_degrees, [15:9] zero
  output logic [15:0] m_axis_tdata_o
);

  localparam int unsigned ZI_W = Z_W - ANGLE_FRAC;  // whole degrees of the angle

  // The pipeline moves as one: every stage advances when the output register
  // is empty or being read.
  logic adv;

  logic signed [XY_W-1:0] x_q [CORDIC_STEPS+1];
  logic signed [XY_W-1:0] y_q [CORDIC_STEPS+1];
  logic signed [Z_W-1:0]  z_q [CORDIC_STEPS+1];
  chm_flags_t             f_q [CORDIC_STEPS+1];
  logic                   vld_q [CORDIC_STEPS+1];

  logic [HEAD_W-1:0] heading_q, heading_d;
  logic              ovld_q;

  // Input stage: join the byte pairs and fold the left half plane onto the right.
  logic signed [15:0]     xs, ys;
  logic signed [XY_W-1:0] xw, yw;
  logic signed [XY_W-1:0] x0_d, y0_d;
  logic signed [Z_W-1:0]  z0_d;
  chm_flags_t             f0_d;

  assign adv             = !ovld_q || m_axis_tready_i;
  assign s_axis_tready_o = adv;

  always_comb begin
    xs = $signed({s_axis_tdata_i[15:8], s_axis_tdata_i[7:0]});
    ys = $signed({s_axis_tdata_i[31:24], s_axis_tdata_i[23:16]});
    xw = $signed({{(XY_W-16-XY_FRAC){xs[15]}}, xs, {XY_FRAC{1'b0}}});
    yw = $signed({{(XY_W-16-XY_FRAC){ys[15]}}, ys, {XY_FRAC{1'b0}}});
    f0_d.yzero = (ys == 16'sd0);
    f0_d.xneg  = xs[15];
    if (!xs[15]) begin
      x0_d = xw;
      y0_d = yw;
      z0_d = '0;
    end else if (!ys[15]) begin
      // Turn clockwise by a quarter turn; the angle starts at +90.
      x0_d = yw;
      y0_d = -xw;
      z0_d = QUARTER_TURN_Z;
    end else begin
      // Turn counterclockwise by a quarter turn; the angle starts at -90.
      x0_d = -yw;
      y0_d = xw;
      z0_d = -QUARTER_TURN_Z;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x_q[0] <= x0_d;
      y_q[0] <= y0_d;
      z_q[0] <= z0_d;
      f_q[0] <= f0_d;
    end
  end

  // One CORDIC iteration per stage. A zero or positive Y turns clockwise and
  // adds the table angle; shifts are arithmetic, so they floor.
  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_stage
    logic signed [XY_W-1:0] xsh, ysh;
    logic signed [XY_W-1:0] x_d, y_d;
    logic signed [Z_W-1:0]  z_d;

    always_comb begin
      xsh = x_q[k] >>> k;
      ysh = y_q[k] >>> k;
      if (!y_q[k][XY_W-1]) begin
        x_d = x_q[k] + ysh;
        y_d = y_q[k] - xsh;
        z_d = z_q[k] + ATAN_TAB[k];
      end else begin
        x_d = x_q[k] - ysh;
        y_d = y_q[k] + xsh;
        z_d = z_q[k] - ATAN_TAB[k];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (adv) begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        x_q[k+1] <= x_d;
        y_q[k+1] <= y_d;
        z_q[k+1] <= z_d;
        f_q[k+1] <= f_q[k];
      end
    end
  end

  // Output stage: floor the angle to whole degrees, offset by a half turn and
  // clamp to 0..360; a zero Y sample takes the bypass heading instead.
  logic signed [ZI_W-1:0] zi;
  logic signed [ZI_W:0]   dsum;

  always_comb begin
    zi   = z_q[CORDIC_STEPS][Z_W-1:ANGLE_FRAC];
    dsum = $signed({zi[ZI_W-1], zi}) + $signed({2'b00, HALF_TURN_DEG});
    if (f_q[CORDIC_STEPS].yzero) begin
      heading_d = f_q[CORDIC_STEPS].xneg ? FULL_TURN_DEG : HALF_TURN_DEG;
    end else if (dsum[ZI_W]) begin
      heading_d = '0;
    end else if (dsum > $signed({2'b00, FULL_TURN_DEG})) begin
      heading_d = FULL_TURN_DEG;
    end else begin
      heading_d = dsum[HEAD_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovld_q <= 1'b0;
    end else if (adv) begin
      ovld_q <= vld_q[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      heading_q <= heading_d;
    end
  end

  assign m_axis_tvalid_o = ovld_q;
  assign m_axis_tdata_o  = {{(16-HEAD_W){1'b0}}, heading_q};

  // The heading handed out never leaves 0..360.
  a_heading_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovld_q |-> (heading_q <= FULL_TURN_DEG))
    else $error("heading out of range");

  // After the quadrant fold the CORDIC always starts in the right half plane.
  a_fold_right: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[0] && !f_q[0].yzero) |-> !x_q[0][XY_W-1])
    else $error("quadrant fold left X negative");

  // A zero Y sample yields the exact bypass heading.
  a_bypass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && vld_q[CORDIC_STEPS] && f_q[CORDIC_STEPS].yzero) |=>
      (heading_q == ($past(f_q[CORDIC_STEPS].xneg) ? FULL_TURN_DEG : HALF_TURN_DEG)))
    else $error("zero Y bypass heading wrong");

  // The input side is only held off while a word waits at the output.
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (ovld_q && !m_axis_tready_i))
    else $error("input stalled without a waiting output word");

endmodule
